// ===== hdl/mcle_pkg.sv =====
// Package for the multi-console line editor.
// Holds key codes, opcodes, read status codes, default sizes and the result type.
// No dependencies.
`default_nettype none

package mcle_pkg;

    // default sizes for the top level parameters
    localparam int DEF_BUF_DEPTH    = 128;
    localparam int DEF_NUM_CONSOLES = 4;

    // item opcodes
    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // read status codes
    localparam logic [2:0] RS_NONE  = 3'd0;
    localparam logic [2:0] RS_BYTE  = 3'd1;
    localparam logic [2:0] RS_LINE  = 3'd2;
    localparam logic [2:0] RS_EOF   = 3'd3;
    localparam logic [2:0] RS_EMPTY = 3'd4;

    // key codes
    localparam logic [7:0] KEY_NUL    = 8'h00;
    localparam logic [7:0] KEY_CTRL_B = 8'h02;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_CTRL_F = 8'h06;
    localparam logic [7:0] KEY_CTRL_H = 8'h08;
    localparam logic [7:0] KEY_LF     = 8'h0A;
    localparam logic [7:0] KEY_CR     = 8'h0D;
    localparam logic [7:0] KEY_CTRL_P = 8'h10;
    localparam logic [7:0] KEY_CTRL_T = 8'h14;
    localparam logic [7:0] KEY_CTRL_U = 8'h15;
    localparam logic [7:0] KEY_DEL    = 8'h7F;

    localparam logic [7:0] ERASE_MAX  = 8'hFF;

    // one result item
    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic [7:0] erase_count;
        logic [2:0] read_status;
        logic [7:0] read_char;
        logic       line_ready;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/mcle_ptr_mem.sv =====
// Per-console pointer memory: read, commit and edit pointers packed in one entry.
// Registered read; per-entry valid bits make unwritten entries read as zero.
// Uses mcle_pkg.
`default_nettype none

module mcle_ptr_mem
    import mcle_pkg::*;
#(
    parameter int NUM_CONSOLES = DEF_NUM_CONSOLES,
    parameter int ENT_W        = 24,
    localparam int CW          = (NUM_CONSOLES > 1) ? $clog2(NUM_CONSOLES) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CW-1:0]    i_raddr,
    output logic      [ENT_W-1:0] o_rdata,
    input  wire logic             i_we,
    input  wire logic [CW-1:0]    i_waddr,
    input  wire logic [ENT_W-1:0] i_wdata
);

    logic [ENT_W-1:0]        r_mem [NUM_CONSOLES];
    logic [NUM_CONSOLES-1:0] r_vld;
    logic [ENT_W-1:0]        r_q;
    logic                    r_q_vld;

    // storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    // valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_q_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_q_vld ? r_q : '0;

endmodule

`default_nettype wire

// ===== hdl/mcle_line_mem.sv =====
// Line store: one ring of bytes per console, addressed as {console, slot}.
// Single write port, single read port with registered read.
// Uses mcle_pkg.
`default_nettype none

module mcle_line_mem
    import mcle_pkg::*;
#(
    parameter int AW = 9
) (
    input  wire logic          i_clk,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata
);

    logic [7:0] r_mem [2**AW];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ===== hdl/mcle_ctrl.sv =====
// Sequencer of the line editor: takes an item, reads the console's pointers,
// edits or reads the line store, writes back and holds the result item.
// Uses mcle_pkg; drives mcle_ptr_mem and mcle_line_mem.
`default_nettype none

module mcle_ctrl
    import mcle_pkg::*;
#(
    parameter int BUF_DEPTH    = DEF_BUF_DEPTH,
    parameter int NUM_CONSOLES = DEF_NUM_CONSOLES,
    localparam int PW          = $clog2(2 * BUF_DEPTH),
    localparam int SW          = $clog2(BUF_DEPTH),
    localparam int CW          = (NUM_CONSOLES > 1) ? $clog2(NUM_CONSOLES) : 1,
    localparam int EW          = 3 * PW,
    localparam int AW          = CW + SW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // item input
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [1:0]    i_opcode,
    input  wire logic [7:0]    i_data_char,
    input  wire logic [1:0]    i_console_index,
    input  wire logic          i_first_of_read,
    // result output
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output t_result            o_result,
    output logic      [1:0]    o_active_now,
    // pointer memory
    output logic      [CW-1:0] o_ptr_raddr,
    input  wire logic [EW-1:0] i_ptr_rdata,
    output logic               o_ptr_we,
    output logic      [CW-1:0] o_ptr_waddr,
    output logic      [EW-1:0] o_ptr_wdata,
    // line store
    output logic      [AW-1:0] o_line_raddr,
    input  wire logic [7:0]    i_line_rdata,
    output logic               o_line_we,
    output logic      [AW-1:0] o_line_waddr,
    output logic      [7:0]    o_line_wdata
);

    localparam int PMOD = 2 * BUF_DEPTH;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_RDATA = 3'd3;
    localparam logic [2:0] S_KILL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // pointer arithmetic modulo twice the ring depth
    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(PMOD - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] f_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(PMOD - 1) : p - PW'(1);
    endfunction

    function automatic logic [SW-1:0] f_slot(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p >= PW'(BUF_DEPTH)) ? p - PW'(BUF_DEPTH) : p;
        return q[SW-1:0];
    endfunction

    function automatic logic [PW:0] f_used(input logic [PW-1:0] e, input logic [PW-1:0] r);
        logic [PW:0] s;
        s = {1'b0, e} + (PW+1)'(PMOD) - {1'b0, r};
        if (s >= (PW+1)'(PMOD)) begin
            s = s - (PW+1)'(PMOD);
        end
        return s;
    endfunction

    logic [2:0]    r_state,    n_state;
    logic [CW-1:0] r_active,   n_active;
    logic [1:0]    r_op,       n_op;
    logic [7:0]    r_char,     n_char;
    logic [CW-1:0] r_con,      n_con;
    logic          r_in_range, n_in_range;
    logic          r_first,    n_first;
    logic [PW-1:0] r_rd,       n_rd;
    logic [PW-1:0] r_cm,       n_cm;
    logic [PW-1:0] r_ed,       n_ed;
    logic [7:0]    r_cnt,      n_cnt;
    t_result       r_res,      n_res;
    t_result       r_out,      n_out;
    logic [1:0]    r_out_act,  n_out_act;
    logic          r_out_valid, n_out_valid;

    logic          in_accept;
    logic          idx_ok;
    logic [PW:0]   used_now;
    logic [7:0]    key_store;
    logic [PW-1:0] ed_next;
    logic          commit;
    logic [PW-1:0] kill_ed;
    logic [7:0]    cnt_inc;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign idx_ok    = ({30'b0, i_console_index} < 32'(NUM_CONSOLES));

    // helpers for key storage and the kill-line walk
    assign used_now  = f_used(r_ed, r_rd);
    assign key_store = (r_char == KEY_CR) ? KEY_LF : r_char;
    assign ed_next   = f_inc(r_ed);
    assign commit    = (key_store == KEY_LF) || (key_store == KEY_CTRL_D) ||
                       (f_used(ed_next, r_rd) == (PW+1)'(BUF_DEPTH));
    assign kill_ed   = f_dec(r_ed);
    assign cnt_inc   = (r_cnt == ERASE_MAX) ? r_cnt : r_cnt + 8'd1;

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_op        = r_op;
        n_char      = r_char;
        n_con       = r_con;
        n_in_range  = r_in_range;
        n_first     = r_first;
        n_rd        = r_rd;
        n_cm        = r_cm;
        n_ed        = r_ed;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out       = r_out;
        n_out_act   = r_out_act;
        n_out_valid = r_out_valid && i_out_stall;

        o_ptr_raddr  = r_con;
        o_ptr_we     = 1'b0;
        o_ptr_waddr  = r_con;
        o_ptr_wdata  = {r_rd, r_cm, r_ed};
        o_line_raddr = {r_con, f_slot(r_rd)};
        o_line_we    = 1'b0;
        o_line_waddr = {r_con, f_slot(r_ed)};
        o_line_wdata = key_store;

        unique case (r_state)
            S_IDLE: begin
                // keys go to the active console, reads and writes name theirs
                if (i_opcode == OP_KEY) begin
                    o_ptr_raddr = r_active;
                end else begin
                    o_ptr_raddr = CW'(i_console_index);
                end
                if (in_accept) begin
                    n_op       = i_opcode;
                    n_char     = i_data_char;
                    n_con      = o_ptr_raddr;
                    n_in_range = (i_opcode == OP_KEY) || idx_ok;
                    n_first    = i_first_of_read;
                    n_res      = '0;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                n_rd    = i_ptr_rdata[3*PW-1:2*PW];
                n_cm    = i_ptr_rdata[2*PW-1:PW];
                n_ed    = i_ptr_rdata[PW-1:0];
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_op)
                    OP_KEY: begin
                        case (r_char) inside
                            KEY_CTRL_U: begin
                                // start the walk at the character before the edit point
                                o_line_raddr = {r_con, f_slot(kill_ed)};
                                n_cnt        = '0;
                                if (r_ed != r_cm) begin
                                    n_state = S_KILL;
                                end
                            end
                            KEY_CTRL_H, KEY_DEL: begin
                                if (r_ed != r_cm) begin
                                    o_ptr_we          = 1'b1;
                                    o_ptr_wdata       = {r_rd, r_cm, kill_ed};
                                    n_res.erase_count = 8'd1;
                                end
                            end
                            KEY_CTRL_B: begin
                                n_active = (r_active == '0) ? CW'(NUM_CONSOLES - 1)
                                                            : r_active - CW'(1);
                            end
                            KEY_CTRL_F: begin
                                n_active = (r_active == CW'(NUM_CONSOLES - 1)) ? '0
                                                            : r_active + CW'(1);
                            end
                            KEY_NUL, KEY_CTRL_P, KEY_CTRL_T: begin
                                // consumed without effect
                            end
                            default: begin
                                // store and echo when the ring has room
                                if (used_now < (PW+1)'(BUF_DEPTH)) begin
                                    o_line_we        = 1'b1;
                                    o_ptr_we         = 1'b1;
                                    o_ptr_wdata      = {r_rd, commit ? ed_next : r_cm, ed_next};
                                    n_res.echo_valid = 1'b1;
                                    n_res.echo_char  = key_store;
                                    n_res.line_ready = commit;
                                end
                            end
                        endcase
                    end
                    OP_READ: begin
                        if (!r_in_range || r_rd == r_cm) begin
                            n_res.read_status = RS_EMPTY;
                        end else begin
                            n_state = S_RDATA;
                        end
                    end
                    OP_WRITE: begin
                        if (r_in_range && r_con == r_active) begin
                            n_res.echo_valid = 1'b1;
                            n_res.echo_char  = r_char;
                        end
                    end
                    default: begin
                        // unknown opcode: empty result
                    end
                endcase
            end
            S_RDATA: begin
                n_state     = S_DONE;
                o_ptr_wdata = {f_inc(r_rd), r_cm, r_ed};
                if (i_line_rdata == KEY_CTRL_D) begin
                    // end of file; the Ctrl-D stays unless this is the first byte
                    n_res.read_status = RS_EOF;
                    o_ptr_we          = r_first;
                end else begin
                    o_ptr_we          = 1'b1;
                    n_res.read_status = (i_line_rdata == KEY_LF) ? RS_LINE : RS_BYTE;
                    n_res.read_char   = i_line_rdata;
                end
            end
            S_KILL: begin
                // i_line_rdata is the character just before r_ed
                if (i_line_rdata == KEY_LF) begin
                    o_ptr_we          = 1'b1;
                    n_res.erase_count = r_cnt;
                    n_state           = S_DONE;
                end else begin
                    n_ed  = kill_ed;
                    n_cnt = cnt_inc;
                    if (kill_ed == r_cm) begin
                        o_ptr_we          = 1'b1;
                        o_ptr_wdata       = {r_rd, r_cm, kill_ed};
                        n_res.erase_count = cnt_inc;
                        n_state           = S_DONE;
                    end else begin
                        o_line_raddr = {r_con, f_slot(f_dec(kill_ed))};
                    end
                end
            end
            S_DONE: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_act   = 2'(r_active);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_char     <= n_char;
        r_con      <= n_con;
        r_in_range <= n_in_range;
        r_first    <= n_first;
        r_rd       <= n_rd;
        r_cm       <= n_cm;
        r_ed       <= n_ed;
        r_cnt      <= n_cnt;
        r_res      <= n_res;
        r_out      <= n_out;
        r_out_act  <= n_out_act;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_result     = r_out;
    assign o_active_now = r_out_act;

endmodule

`default_nettype wire

// ===== hdl/multi_console_line_editor_top.sv =====
// Line editor for several consoles: item input, result output, the sequencer
// and the two state memories. Uses mcle_pkg, mcle_ctrl, mcle_ptr_mem, mcle_line_mem.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: a received key, a
//   one-byte read or a one-byte write. Output channel (o_out_valid / i_out_stall)
//   returns exactly one result item per input item, in order.
//   Sequence: an accepted item passes the load, execute and done states before
//   its result enters the result register; a read adds a line-store read state
//   before done, and Ctrl-U adds the kill walk, whose n (at most BUF_DEPTH)
//   line-store reads are one per character erased, plus one when the walk stops
//   at a newline; one read per cycle, single port.
//   Flow: one item at a time; the next item is taken the cycle after the
//   result is handed to the output register.
//   Reset clears the pointers of all consoles (via valid bits on the pointer
//   memory) and makes console 0 active; the line store needs no clearing.
//   While the receiver stalls, the result is held and one more item may be
//   processed up to its result; further input is stalled until the output frees.
`default_nettype none

module multi_console_line_editor_top
    import mcle_pkg::*;
#(
    parameter int BUF_DEPTH    = DEF_BUF_DEPTH,
    parameter int NUM_CONSOLES = DEF_NUM_CONSOLES
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic [7:0] i_data_char,
    input  wire logic [1:0] i_console_index,
    input  wire logic       i_first_of_read,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_echo_valid,
    output logic [7:0]      o_echo_char,
    output logic [7:0]      o_erase_count,
    output logic [2:0]      o_read_status,
    output logic [7:0]      o_read_char,
    output logic            o_line_ready,
    output logic [1:0]      o_active_now
);

    localparam int PW = $clog2(2 * BUF_DEPTH);
    localparam int SW = $clog2(BUF_DEPTH);
    localparam int CW = (NUM_CONSOLES > 1) ? $clog2(NUM_CONSOLES) : 1;
    localparam int EW = 3 * PW;
    localparam int AW = CW + SW;

    t_result          result;
    logic [CW-1:0]    ptr_raddr;
    logic [EW-1:0]    ptr_rdata;
    logic             ptr_we;
    logic [CW-1:0]    ptr_waddr;
    logic [EW-1:0]    ptr_wdata;
    logic [AW-1:0]    line_raddr;
    logic [7:0]       line_rdata;
    logic             line_we;
    logic [AW-1:0]    line_waddr;
    logic [7:0]       line_wdata;

    // sequencer
    mcle_ctrl #(
        .BUF_DEPTH    (BUF_DEPTH),
        .NUM_CONSOLES (NUM_CONSOLES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_data_char     (i_data_char),
        .i_console_index (i_console_index),
        .i_first_of_read (i_first_of_read),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result        (result),
        .o_active_now    (o_active_now),
        .o_ptr_raddr     (ptr_raddr),
        .i_ptr_rdata     (ptr_rdata),
        .o_ptr_we        (ptr_we),
        .o_ptr_waddr     (ptr_waddr),
        .o_ptr_wdata     (ptr_wdata),
        .o_line_raddr    (line_raddr),
        .i_line_rdata    (line_rdata),
        .o_line_we       (line_we),
        .o_line_waddr    (line_waddr),
        .o_line_wdata    (line_wdata)
    );

    // per-console pointers
    mcle_ptr_mem #(
        .NUM_CONSOLES (NUM_CONSOLES),
        .ENT_W        (EW)
    ) u_ptr_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (ptr_raddr),
        .o_rdata (ptr_rdata),
        .i_we    (ptr_we),
        .i_waddr (ptr_waddr),
        .i_wdata (ptr_wdata)
    );

    // character rings
    mcle_line_mem #(
        .AW (AW)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata),
        .i_we    (line_we),
        .i_waddr (line_waddr),
        .i_wdata (line_wdata)
    );

    assign o_echo_valid  = result.echo_valid;
    assign o_echo_char   = result.echo_char;
    assign o_erase_count = result.erase_count;
    assign o_read_status = result.read_status;
    assign o_read_char   = result.read_char;
    assign o_line_ready  = result.line_ready;

endmodule

`default_nettype wire

// ===== hdl/mcle_checker.sv =====
// Port-level checker for the line editor, bound to the top level.
// Uses mcle_pkg for read status codes.
`default_nettype none

module mcle_checker
    import mcle_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_echo_valid,
    input wire logic [7:0] o_echo_char,
    input wire logic [7:0] o_erase_count,
    input wire logic [2:0] o_read_status,
    input wire logic [7:0] o_read_char,
    input wire logic       o_line_ready,
    input wire logic [1:0] o_active_now
);

    // an accepted item keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted item");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_echo_char) && $stable(o_read_status) &&
             $stable(o_erase_count) && $stable(o_active_now)))
        else $error("stalled result changed");

    // a read result never echoes or commits a line
    a_read_no_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_status != RS_NONE) |-> (!o_echo_valid && !o_line_ready &&
                                                       o_erase_count == 8'd0))
        else $error("read result carries key effects");

    // delivered byte only with a byte status
    a_read_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_status != RS_BYTE && o_read_status != RS_LINE)
            |-> (o_read_char == 8'd0))
        else $error("read byte without byte status");

    // a committed line always comes with an echo
    a_commit_echoes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line_ready) |-> o_echo_valid)
        else $error("line committed without echo");

endmodule

bind multi_console_line_editor_top mcle_checker u_mcle_checker (.*);

`default_nettype wire
